>>> rtl/core/linear_probe_hash_insert_defines.svh
// Assertion macros shared by the hash insert RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef LINEAR_PROBE_HASH_INSERT_DEFINES_SVH
`define LINEAR_PROBE_HASH_INSERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPH_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/core/lph_pkg.sv
// Types and constants of the linear probing hash insert block.
// No dependencies; imported by every module of the block but lph_ram.
package lph_pkg;

    localparam int DEF_TABLE_DEPTH = 2048;
    localparam int DEF_KEY_WIDTH   = 31;
    localparam int SIZE_W          = 12;
    localparam int SLOT_W          = 11;
    localparam int STATUS_W        = 2;
    localparam int OUT_DATA_W      = ((SLOT_W + 7) / 8) * 8;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 12'd2048;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_PRESENT  = 2'd1,
        STATUS_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_PROBE
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_result;

endpackage

>>> rtl/core/lph_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/lph_mod.sv
// Remainder unit: key modulo table size, one key bit per cycle (restoring).
// Depends on lph_pkg.
module lph_mod import lph_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int SW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [SW-1:0]        i_size,
    output logic                 o_done,
    output logic [AW-1:0]        o_rem
);

    localparam int CNT_W = $clog2(KEY_WIDTH);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [KEY_WIDTH-1:0] r_key;
    logic [SW-1:0]        r_size;
    logic [AW-1:0]        r_rem;
    logic [AW:0]          w_trial;
    logic [AW:0]          w_diff;
    logic [AW-1:0]        n_rem;

    assign w_trial = {r_rem, r_key[KEY_WIDTH-1]};
    assign w_diff  = w_trial - (AW+1)'(r_size);
    assign n_rem   = (w_trial >= (AW+1)'(r_size)) ? w_diff[AW-1:0] : w_trial[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(KEY_WIDTH - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key  <= i_key;
            r_size <= i_size;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_key  <= r_key << 1;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/lph_probe.sv
// Probe sequencer: clearing pass, linear probe over the slot RAM, insert write.
// Depends on lph_pkg, lph_ram and the assertion macro header.
`include "linear_probe_hash_insert_defines.svh"

module lph_probe import lph_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int SW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [SW-1:0]        i_size,
    input  logic                 i_mod_done,
    input  logic [AW-1:0]        i_rem,
    input  logic                 i_out_free,
    output logic                 o_ready,
    output logic                 o_res_vld,
    output t_result              o_result
);

    localparam int MW = KEY_WIDTH + 1;

    t_state               r_state;
    t_state               n_state;
    logic [AW-1:0]        r_fill;
    logic                 r_chk;
    logic [KEY_WIDTH-1:0] r_key;
    logic [SW-1:0]        r_size;
    logic [SW-1:0]        r_cnt;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_chk_pos;

    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [MW-1:0]        w_wr_data;
    logic                 w_rd_en;
    logic [MW-1:0]        w_rd_data;

    logic                 w_rd_valid;
    logic                 w_hit_empty;
    logic                 w_hit_key;
    logic                 w_full;
    logic                 w_finish;
    logic                 w_issue;
    logic [SW-1:0]        w_pos_inc;
    logic [AW-1:0]        w_pos_next;
    logic [AW+SLOT_W-1:0] w_slot_ext;

    lph_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_pos),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_valid  = w_rd_data[KEY_WIDTH];
    assign w_hit_empty = r_chk && !w_rd_valid;
    assign w_hit_key   = r_chk && w_rd_valid && (w_rd_data[KEY_WIDTH-1:0] == r_key);
    assign w_full      = !r_chk && (r_cnt == r_size);
    assign w_finish    = w_hit_empty || w_hit_key || w_full;
    assign w_issue     = (r_cnt != r_size);
    assign w_pos_inc   = SW'(r_pos) + SW'(1);
    assign w_pos_next  = (w_pos_inc >= r_size) ? '0 : w_pos_inc[AW-1:0];
    assign w_slot_ext  = {{SLOT_W{1'b0}}, r_chk_pos};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_fill == AW'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (i_mod_done) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_out_free && w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_res_vld = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_fill;
        w_wr_data = '0;
        w_rd_en   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_wr_en = 1'b1;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_DIVIDE: begin
                o_ready = 1'b0;
            end
            ST_PROBE: begin
                if (i_out_free) begin
                    if (w_finish) begin
                        o_res_vld = 1'b1;
                        if (w_hit_empty) begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_chk_pos;
                            w_wr_data = {1'b1, r_key};
                        end
                    end else begin
                        w_rd_en = w_issue;
                    end
                end
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_comb begin
        o_result.slot   = w_full ? '0 : w_slot_ext[SLOT_W-1:0];
        o_result.status = w_hit_empty ? STATUS_INSERTED :
                          (w_hit_key ? STATUS_PRESENT : STATUS_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_fill  <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_fill <= r_fill + AW'(1);
            end
            if (r_state != ST_PROBE) begin
                r_chk <= 1'b0;
            end else if (i_out_free) begin
                r_chk <= !w_finish && w_issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_key  <= i_key;
            r_size <= i_size;
        end
        if (r_state == ST_DIVIDE && i_mod_done) begin
            r_pos <= i_rem;
            r_cnt <= '0;
        end
        if (r_state == ST_PROBE && i_out_free && !w_finish) begin
            r_chk_pos <= r_pos;
            r_pos     <= w_pos_next;
            if (w_issue) begin
                r_cnt <= r_cnt + SW'(1);
            end
        end
    end

    `LPH_ASSERT_NOW(a_pos_in_range, i_clk, i_rst_n, r_state == ST_PROBE, SW'(r_pos) < r_size, "probe position beyond table size")
    `LPH_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, r_state == ST_PROBE, r_cnt <= r_size, "probe count beyond table size")
    `LPH_ASSERT_NOW(a_done_in_divide, i_clk, i_rst_n, i_mod_done, r_state == ST_DIVIDE, "remainder ready outside divide")
    `LPH_ASSERT_NEXT(a_idle_after_result, i_clk, i_rst_n, o_res_vld, r_state == ST_IDLE, "no return to idle after result")

endmodule

>>> rtl/core/linear_probe_hash_insert.sv
// Top level of the linear probing hash insert block: size register, output register.
// Depends on lph_pkg, lph_mod and lph_probe.
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready    tdata: key
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready    tdata: slot, tuser: status
//  cfg       in   i_cfg_wr_en                        i_cfg_wr_data: table_size
//
//  After reset a clearing pass writes every slot of the table before the first request.
//  A request is handled in steps: the remainder unit resolves one key bit a cycle,
//  then the probe issues one slot read per cycle while the output register is free,
//  at most as many slot reads as the table size.
//  A result held in the output register freezes the probe until it is taken; a new
//  request is still accepted and its remainder computed meanwhile.
module linear_probe_hash_insert import lph_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    localparam int IN_DATA_W = ((KEY_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // key, zero pad
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // slot, zero pad
    output logic [STATUS_W-1:0]   o_m_axis_tuser,   // status
    input  logic                  i_cfg_wr_en,
    input  logic [SIZE_W-1:0]     i_cfg_wr_data     // table_size
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (SW > SIZE_W) ? SW : SIZE_W;

    logic [SIZE_W-1:0] r_table_size;
    logic [CW-1:0]     w_size_ext;
    logic [CW-1:0]     w_size_sat;
    logic [SW-1:0]     w_size;
    logic              w_start;
    logic              w_ready;
    logic              w_mod_done;
    logic [AW-1:0]     w_rem;
    logic              w_out_free;
    logic              w_res_vld;
    t_result           w_result;
    logic              r_out_vld;
    t_result           r_out;

    assign w_size_ext = CW'(r_table_size);
    assign w_size_sat = (w_size_ext == '0) ? CW'(1) :
                        ((w_size_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : w_size_ext);
    assign w_size     = w_size_sat[SW-1:0];
    assign w_start    = i_s_axis_tvalid && w_ready;
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_table_size <= i_cfg_wr_data;
        end
    end

    lph_mod #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_key   (i_s_axis_tdata[KEY_WIDTH-1:0]),
        .i_size  (w_size),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    lph_probe #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_probe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_key      (i_s_axis_tdata[KEY_WIDTH-1:0]),
        .i_size     (w_size),
        .i_mod_done (w_mod_done),
        .i_rem      (w_rem),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_res_vld  (w_res_vld),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_vld) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld) begin
            r_out <= w_result;
        end
    end

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out.slot);
    assign o_m_axis_tuser  = r_out.status;

endmodule

>>> tb/lph_insert_checker.sv
// Scoreboard for the linear probing hash insert block: watches the request, result and
// size-write channels, keeps its own copy of the table and compares every result.
// Depends on lph_pkg.
module lph_insert_checker import lph_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    localparam int IN_DATA_W = ((KEY_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // key, zero pad
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // slot, zero pad
    input  logic [STATUS_W-1:0]   i_m_tuser,   // status
    input  logic                  i_cfg_wr_en,
    input  logic [SIZE_W-1:0]     i_cfg_wr_data,
    output int                    o_mismatches,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [KEY_WIDTH-1:0] stored_key [TABLE_DEPTH];
    bit                   occupied   [TABLE_DEPTH];
    logic [SIZE_W-1:0]    table_size;
    t_result              awaited_placements [$];
    int                   results_seen;

    function automatic t_result place_key(input logic [KEY_WIDTH-1:0] key);
        int unsigned span;
        int unsigned pos;
        t_result     res;
        bit          settled;
        span = table_size;
        if (span == 0) span = 1;
        if (span > TABLE_DEPTH) span = TABLE_DEPTH;
        pos        = key % span;
        res.slot   = '0;
        res.status = STATUS_FULL;
        settled    = 1'b0;
        for (int n = 0; n < span && !settled; n++) begin
            if (!occupied[pos]) begin
                occupied[pos]   = 1'b1;
                stored_key[pos] = key;
                res.slot        = pos[SLOT_W-1:0];
                res.status      = STATUS_INSERTED;
                settled         = 1'b1;
            end else if (stored_key[pos] == key) begin
                res.slot   = pos[SLOT_W-1:0];
                res.status = STATUS_PRESENT;
                settled    = 1'b1;
            end else begin
                pos = (pos + 1 == span) ? 0 : pos + 1;
            end
        end
        return res;
    endfunction

    task automatic log_mismatch(input string what);
        $display("%0t ns result %0d: %s", $realtime, results_seen, what);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            table_size = TABLE_SIZE_RESET;
            foreach (occupied[i]) occupied[i] = 1'b0;
            awaited_placements.delete();
            results_seen = 0;
            o_mismatches = 0;
        end else begin
            if (i_cfg_wr_en) table_size = i_cfg_wr_data;
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_placements.size() == 0) begin
                    log_mismatch($sformatf("slot %0d status %0d with no request outstanding",
                                           i_m_tdata[SLOT_W-1:0], i_m_tuser));
                end else begin
                    want = awaited_placements.pop_front();
                    if (i_m_tdata[SLOT_W-1:0] !== want.slot)
                        log_mismatch($sformatf("slot %0d, want %0d",
                                               i_m_tdata[SLOT_W-1:0], want.slot));
                    if (i_m_tuser !== want.status)
                        log_mismatch($sformatf("status %0d, want %s",
                                               i_m_tuser, want.status.name()));
                end
                results_seen++;
            end
            if (i_s_tvalid && i_s_tready)
                awaited_placements.push_back(place_key(i_s_tdata[KEY_WIDTH-1:0]));
        end
        o_outstanding = awaited_placements.size();
    end

endmodule

>>> tb/linear_probe_hash_insert_tb.sv
// Top of the hash insert testbench: clock, reset, key requests, size writes and
// result back-pressure, with the verdict. Depends on lph_pkg, lph_insert_checker
// and the linear_probe_hash_insert RTL.
module linear_probe_hash_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lph_pkg::*;

    localparam int KEY_W         = DEF_KEY_WIDTH;
    localparam int IN_DATA_W     = ((KEY_W + 7) / 8) * 8;
    localparam int IDLE_MAX      = 10;
    localparam int SETTLE_CYCLES = 48;
    localparam int TAIL_CYCLES   = 128;
    localparam int STALL_LIMIT   = 25000;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 830;
    localparam int HISTORY_DEPTH = 256;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_wr_en;
    logic [SIZE_W-1:0]     cfg_wr_data;
    int                    mismatches;
    int                    outstanding;
    int                    quiet_cycles;
    int                    sender_gap_max;
    logic [KEY_W-1:0]      key_history [$];

    linear_probe_hash_insert i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    lph_insert_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_key(input logic [KEY_W-1:0] key);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - KEY_W){1'b0}}, key};
        key_history.push_back(key);
        if (key_history.size() > HISTORY_DEPTH) void'(key_history.pop_front());
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    task automatic finish_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_table_size(input logic [SIZE_W-1:0] size_code);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size_code;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // result side: random or no stalls, one long hold-off
    initial begin
        int gap;
        int taken;
        m_tready = 1'b0;
        taken    = 0;
        forever begin
            gap = ((taken / 50) % 3 == 1) ? 0 : $urandom_range(0, IDLE_MAX);
            if (taken == HOLD_AT) gap = HOLD_CYCLES;
            @(negedge clk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    initial begin
        logic [SIZE_W-1:0] size_code;
        logic [KEY_W-1:0]  key;
        int unsigned       span;
        int                burst_len;
        int                sent;
        int                phase_no;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        quiet_cycles   = 0;
        sender_gap_max = IDLE_MAX;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset size: home slots at both ends, wrap past the last slot, repeats
        send_key(31'd0);
        send_key(31'h7FFF_FFFF);
        send_key(31'd4095);
        send_key(31'd0);
        send_key(31'd2048);
        send_key(31'h5555_5555);
        send_key(31'h2AAA_AAAA);
        finish_burst();

        // zero size acts as one slot: full table, key still found
        write_table_size(12'd0);
        send_key(31'd5);
        send_key(31'd0);
        finish_burst();

        // oversize saturates to the full depth
        write_table_size(12'hFFF);
        send_key(31'd4095);
        send_key(31'd1);
        finish_burst();

        // shrunk table: upper entries ignored
        write_table_size(12'd3);
        send_key(31'd7);
        send_key(31'd2048);
        send_key(31'd1);
        finish_burst();

        write_table_size(12'd1);
        send_key(31'd0);
        send_key(31'd9);
        finish_burst();

        write_table_size(12'd2048);
        send_key(31'd2047);
        finish_burst();

        phase_no = 0;
        sent     = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase_no == 0) begin
                size_code = 12'd2048;
            end else begin
                case ($urandom_range(0, 9))
                    0:       size_code = 12'd0;
                    1:       size_code = 12'd1;
                    2:       size_code = SIZE_W'($urandom_range(2, 8));
                    3, 4:    size_code = SIZE_W'($urandom_range(9, 64));
                    5:       size_code = SIZE_W'($urandom_range(65, 400));
                    6:       size_code = SIZE_W'($urandom_range(401, 2047));
                    7:       size_code = 12'd2048;
                    8:       size_code = SIZE_W'($urandom_range(2049, 4094));
                    default: size_code = 12'hFFF;
                endcase
            end
            write_table_size(size_code);
            span = (size_code == 0) ? 1 :
                   (size_code > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : size_code;
            sender_gap_max = (phase_no == 0 || $urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
            burst_len = (phase_no == 0) ? 100 : $urandom_range(30, 70);
            repeat (burst_len) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: key = (key_history.size() > 0) ?
                                   key_history[$urandom_range(0, key_history.size() - 1)] :
                                   KEY_W'($urandom);
                    3, 4, 5: key = KEY_W'($urandom_range(0, 4 * span));
                    6:       key = KEY_W'(span * $urandom_range(0, 1000) +
                                          $urandom_range(0, 3));
                    default: key = KEY_W'($urandom);
                endcase
                send_key(key);
            end
            finish_burst();
            sent += burst_len;
            phase_no++;
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/lph_pkg.sv
rtl/core/lph_ram.sv
rtl/core/lph_mod.sv
rtl/core/lph_probe.sv
rtl/core/linear_probe_hash_insert.sv
tb/lph_insert_checker.sv
tb/linear_probe_hash_insert_tb.sv
